/* rtl/pawc_pkg.sv */
// Shared constants, types and the divider step function for the PPDU airtime
// calculator. No dependencies; every other file of the block imports this package.
package pawc_pkg;

    localparam int LEN_WIDTH      = 12;
    localparam int RATE_W         = 8;
    localparam int DUR_W          = 16;
    // The OFDM dividend 16*B + 44 plus (divisor - 1) fits in LEN_WIDTH + 5 bits.
    localparam int NUM_W          = LEN_WIDTH + 5;
    // The divisor is rate * Tsym, with Tsym at most 16.
    localparam int DEN_W          = RATE_W + 4;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = (NUM_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int TOT_W          = NUM_W + 5;
    localparam int OVH_W          = 8;
    localparam int SHIFT_W        = 3;

    localparam logic [DUR_W-1:0] MAX_DURATION = {DUR_W{1'b1}};

    localparam logic [1:0] CLASS_OFDM  = 2'd0;
    localparam logic [1:0] CLASS_ERP   = 2'd1;
    localparam logic [1:0] CLASS_DSSS  = 2'd2;
    localparam logic [1:0] CLASS_UNSUP = 2'd3;

    localparam logic [1:0] BW_10MHZ = 2'd1;
    localparam logic [1:0] BW_5MHZ  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNSUP     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_RATE = 2'd2;
    localparam logic [1:0] STATUS_SAT       = 2'd3;

    localparam logic [OVH_W-1:0] OVH_OFDM_20 = 8'd20;
    localparam logic [OVH_W-1:0] OVH_OFDM_10 = 8'd40;
    localparam logic [OVH_W-1:0] OVH_OFDM_5  = 8'd80;
    // ERP-OFDM preamble plus header plus the 6 us signal extension.
    localparam logic [OVH_W-1:0] OVH_ERP     = 8'd26;
    localparam logic [OVH_W-1:0] OVH_DSSS_L  = 8'd192;
    localparam logic [OVH_W-1:0] OVH_DSSS_S  = 8'd96;

    localparam logic [SHIFT_W-1:0] SHIFT_TSYM_4  = 3'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_TSYM_8  = 3'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_TSYM_16 = 3'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_NONE    = 3'd0;

    localparam logic [NUM_W-1:0] OFDM_NUM_BIAS = NUM_W'(44);

    // Data that rides alongside the divider.
    typedef struct packed {
        logic [1:0]         status;
        logic [OVH_W-1:0]   ovh;
        logic [SHIFT_W-1:0] shift;
    } side_t;

    // Partial state of the restoring divider.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quot;
    } div_state_t;

    // Runs up to BITS_PER_STAGE restoring division steps, MSB of the dividend first.
    function automatic div_state_t div_steps(input div_state_t s, input logic [DEN_W-1:0] den,
                                             input int steps);
        div_state_t     r;
        logic [DEN_W:0] trial;
        r = s;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            if (j < steps) begin
                trial = {r.rem, r.num[NUM_W-1]};
                r.num = {r.num[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, den}) begin
                    r.rem  = DEN_W'(trial - {1'b0, den});
                    r.quot = {r.quot[NUM_W-2:0], 1'b1};
                end
                else begin
                    r.rem  = trial[DEN_W-1:0];
                    r.quot = {r.quot[NUM_W-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/pawc_if.sv */
// Handshake channel interfaces of the PPDU airtime calculator: frame descriptors,
// airtime results and the configuration write channel. Depends on pawc_pkg.
interface pawc_frame_if
    import pawc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           modulation_class;
    logic [1:0]           bandwidth_code;
    logic [RATE_W-1:0]    rate_half_mbps;
    logic [LEN_WIDTH-1:0] payload_bytes;

    modport source (output valid, modulation_class, bandwidth_code, rate_half_mbps,
                    payload_bytes, input ready);
    modport sink (input valid, modulation_class, bandwidth_code, rate_half_mbps,
                  payload_bytes, output ready);
endinterface

interface pawc_airtime_if
    import pawc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] duration_us;
    logic [1:0]       status;

    modport source (output valid, duration_us, status, input ready);
    modport sink (input valid, duration_us, status, output ready);
endinterface

interface pawc_cfg_if;
    logic valid;
    logic ready;
    logic preamble_short;

    modport source (output valid, preamble_short, input ready);
    modport sink (input valid, preamble_short, output ready);
endinterface

/* rtl/pawc_div.sv */
// Pipelined restoring divider with a sideband that travels with each item.
// Depends on pawc_pkg for widths, the side_t type and the div_steps function.
module pawc_div
    import pawc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  side_t            in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [NUM_W-1:0] out_quot,
    output side_t            out_side
);

    logic             valid_reg   [DIV_STAGES];
    div_state_t       st_reg      [DIV_STAGES];
    logic [DEN_W-1:0] den_reg     [DIV_STAGES];
    side_t            side_reg    [DIV_STAGES];

    logic             src_valid   [DIV_STAGES];
    div_state_t       src_st      [DIV_STAGES];
    logic [DEN_W-1:0] src_den     [DIV_STAGES];
    side_t            src_side    [DIV_STAGES];
    div_state_t       st_next     [DIV_STAGES];
    logic             stage_ready [DIV_STAGES];
    logic             down_ready  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int LEFT  = NUM_W - k * BITS_PER_STAGE;
        localparam int STEPS = (LEFT < BITS_PER_STAGE) ? LEFT : BITS_PER_STAGE;

        if (k == 0) begin : g_first
            assign src_valid[k] = in_valid;
            assign src_st[k]    = '{rem: '0, num: in_num, quot: '0};
            assign src_den[k]   = in_den;
            assign src_side[k]  = in_side;
        end
        else begin : g_next
            assign src_valid[k] = valid_reg[k-1];
            assign src_st[k]    = st_reg[k-1];
            assign src_den[k]   = den_reg[k-1];
            assign src_side[k]  = side_reg[k-1];
        end

        if (k == DIV_STAGES - 1) begin : g_last
            assign down_ready[k] = out_ready;
        end
        else begin : g_mid
            assign down_ready[k] = stage_ready[k+1];
        end

        // A stage takes a new item when it is empty or its item moves on.
        assign stage_ready[k] = !valid_reg[k] || down_ready[k];

        always_comb
        begin
            st_next[k] = div_steps(src_st[k], src_den[k], STEPS);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end
            else if (stage_ready[k]) begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[k] && src_valid[k]) begin
                st_reg[k]   <= st_next[k];
                den_reg[k]  <= src_den[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = st_reg[DIV_STAGES-1].quot;
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

/* rtl/wifi_ppdu_airtime_calculator_unit.sv */
// Top level of the 802.11 PPDU airtime calculator.
// Depends on pawc_pkg, the channel interfaces in pawc_if and the divider pawc_div.
//
// Usage:
// A frame descriptor item on the frame channel (class, bandwidth, rate in
// 0.5 Mbit/s units, payload bytes) yields exactly one item on the airtime
// channel: the transmit time in microseconds and a status code.
// The cfg channel writes the preamble_short bit; it is always ready and the
// new value applies to frames accepted after the write.
// Dividend and divisor are formed into the stage 0 register, the divider
// stages then resolve up to four quotient bits each, and the final sum and
// saturation go into the output register. The pipeline accepts one item per
// cycle while the airtime receiver does not stall; the divider stages set
// that figure.
// Each stage holds its item while the next stage cannot take it, so a stalled
// receiver fills the pipeline gradually; bubbles are squeezed out and the
// frame channel stays ready until every stage holds an item.
// Reset clears all valid bits and sets preamble_short to the long preamble.
module wifi_ppdu_airtime_calculator_unit
    import pawc_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    pawc_cfg_if.sink     cfg,
    pawc_frame_if.sink   frame,
    pawc_airtime_if.source airtime
);

    logic preamble_short_reg;

    // Stage 0: dividend, divisor and sideband.
    logic             s0_valid_reg;
    logic [NUM_W-1:0] s0_num_reg;
    logic [DEN_W-1:0] s0_den_reg;
    side_t            s0_side_reg;
    logic [NUM_W-1:0] s0_num_next;
    logic [DEN_W-1:0] s0_den_next;
    side_t            s0_side_next;
    logic [NUM_W-1:0] num_raw;
    logic             s0_ready;

    logic             div_in_ready;
    logic             div_out_valid;
    logic [NUM_W-1:0] div_quot;
    side_t            div_side;

    logic             out_valid_reg;
    logic [DUR_W-1:0] dur_reg;
    logic [1:0]       status_reg;
    logic [DUR_W-1:0] dur_next;
    logic [1:0]       status_next;
    logic [TOT_W-1:0] total;
    logic             out_load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            preamble_short_reg <= 1'b0;
        end
        else if (cfg.valid) begin
            preamble_short_reg <= cfg.preamble_short;
        end
    end

    always_comb
    begin
        num_raw      = {1'b0, frame.payload_bytes, 4'b0000};
        s0_side_next = '{status: STATUS_OK, ovh: OVH_OFDM_20, shift: SHIFT_TSYM_4};
        s0_num_next  = '0;
        s0_den_next  = '0;
        if (frame.modulation_class == CLASS_DSSS) begin
            s0_side_next.ovh   = preamble_short_reg ? OVH_DSSS_S : OVH_DSSS_L;
            s0_side_next.shift = SHIFT_NONE;
            s0_den_next        = DEN_W'(frame.rate_half_mbps);
            s0_num_next        = num_raw;
        end
        else begin
            case (frame.bandwidth_code)
                BW_10MHZ: begin
                    s0_side_next.shift = SHIFT_TSYM_8;
                    s0_side_next.ovh   = OVH_OFDM_10;
                end
                BW_5MHZ: begin
                    s0_side_next.shift = SHIFT_TSYM_16;
                    s0_side_next.ovh   = OVH_OFDM_5;
                end
                default: begin
                    s0_side_next.shift = SHIFT_TSYM_4;
                    s0_side_next.ovh   = OVH_OFDM_20;
                end
            endcase
            if (frame.modulation_class == CLASS_ERP) begin
                s0_side_next.ovh = OVH_ERP;
            end
            s0_den_next = DEN_W'(frame.rate_half_mbps) << s0_side_next.shift;
            s0_num_next = num_raw + OFDM_NUM_BIAS;
        end
        // Ceiling division: bias the dividend by divisor minus one.
        s0_num_next = s0_num_next + NUM_W'(s0_den_next) - NUM_W'(1);
        if (frame.modulation_class == CLASS_UNSUP) begin
            s0_side_next.status = STATUS_UNSUP;
        end
        else if (frame.rate_half_mbps == '0) begin
            s0_side_next.status = STATUS_ZERO_RATE;
        end
    end

    assign s0_ready    = !s0_valid_reg || div_in_ready;
    assign frame.ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready) begin
            s0_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && frame.valid) begin
            s0_num_reg  <= s0_num_next;
            s0_den_reg  <= s0_den_next;
            s0_side_reg <= s0_side_next;
        end
    end

    pawc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (div_in_ready),
        .in_num    (s0_num_reg),
        .in_den    (s0_den_reg),
        .in_side   (s0_side_reg),
        .out_valid (div_out_valid),
        .out_ready (out_load),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Final stage: overhead plus symbols times symbol time, then saturation.
    always_comb
    begin
        total       = TOT_W'(div_side.ovh) + (TOT_W'(div_quot) << div_side.shift);
        status_next = div_side.status;
        dur_next    = total[DUR_W-1:0];
        if (div_side.status != STATUS_OK) begin
            dur_next = '0;
        end
        else if (total > TOT_W'(MAX_DURATION)) begin
            dur_next    = MAX_DURATION;
            status_next = STATUS_SAT;
        end
    end

    assign out_load = !out_valid_reg || airtime.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load) begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && div_out_valid) begin
            dur_reg    <= dur_next;
            status_reg <= status_next;
        end
    end

    assign airtime.valid       = out_valid_reg;
    assign airtime.duration_us = dur_reg;
    assign airtime.status      = status_reg;

endmodule

/* rtl/pawc_checker.sv */
// Port-level assertions for the PPDU airtime calculator and the bind that
// attaches them to wifi_ppdu_airtime_calculator_unit. Depends on pawc_pkg.
module pawc_checker
    import pawc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [DUR_W-1:0] duration_us,
    input logic [1:0]       status
);

    // A result item that is not taken stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duration_us) && $stable(status))
        else $error("stalled airtime item changed");

    // Unsupported class and zero rate report no airtime.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_UNSUP || status == STATUS_ZERO_RATE)
        |-> duration_us == '0)
        else $error("error status with nonzero duration");

    // A saturated result carries the largest duration.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_SAT |-> duration_us == MAX_DURATION)
        else $error("saturated status without maximum duration");

    // Every good frame carries at least the shortest preamble and header.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |-> duration_us >= DUR_W'(OVH_OFDM_20))
        else $error("good frame shorter than the minimum overhead");

endmodule

bind wifi_ppdu_airtime_calculator_unit pawc_checker u_pawc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (airtime.valid),
    .out_ready   (airtime.ready),
    .duration_us (airtime.duration_us),
    .status      (airtime.status)
);
